// ----- rtl/core/event_frame_integrity_checker_assert.svh -----
// assertion macros for the frame checker rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef EVENT_FRAME_INTEGRITY_CHECKER_ASSERT_SVH
`define EVENT_FRAME_INTEGRITY_CHECKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EFIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efic assertion failed");

// next-cycle implication, checked outside reset
`define EFIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efic assertion failed");

`endif

// ----- rtl/core/efic_pkg.sv -----
// types and constants for the event frame integrity checker
// no dependencies
package efic_pkg;

  typedef struct packed {
    logic [31:0] link_word;
    logic        is_control;
  } efic_in_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic        dig_crc_bad;
    logic        global_crc_bad;
    logic        control_bad;
    logic        final_crc_mismatch;
    logic [10:0] words_seen;
    logic [31:0] error_frames;
    logic [31:0] dig_crc_frames;
    logic [31:0] global_crc_frames;
    logic [31:0] control_frames;
  } efic_out_t;

  typedef struct packed {
    logic [5:0]  samples_per_block;
    logic [31:0] open_word;
    logic [31:0] close_word;
    logic [31:0] digitizer_crc_word;
    logic [9:0]  max_data_words;
  } efic_cfg_t;

  typedef struct packed {
    logic final_crc;
    logic ctrl;
    logic glob;
    logic dig;
  } efic_flags_t;

  // register indexes of the config port
  localparam logic [2:0] REG_SAMPLES_PER_BLOCK = 3'd0;
  localparam logic [2:0] REG_OPEN_WORD         = 3'd1;
  localparam logic [2:0] REG_CLOSE_WORD        = 3'd2;
  localparam logic [2:0] REG_DIG_CRC_WORD      = 3'd3;
  localparam logic [2:0] REG_MAX_DATA_WORDS    = 3'd4;

  // reset values of the config registers
  localparam logic [5:0]  RST_SAMPLES_PER_BLOCK = 6'd6;
  localparam logic [31:0] RST_OPEN_WORD         = 32'h5111_5110;
  localparam logic [31:0] RST_CLOSE_WORD        = 32'hFFFF_FFF0;
  localparam logic [31:0] RST_DIG_CRC_WORD      = 32'h3FFF_3FFF;
  localparam logic [9:0]  RST_MAX_DATA_WORDS    = 10'd500;

  // frame status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DIG_CRC    = 3'd1;
  localparam logic [2:0] ST_GLOBAL_CRC = 3'd2;
  localparam logic [2:0] ST_OPEN_WORD  = 3'd3;
  localparam logic [2:0] ST_BAD_STOP   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW   = 3'd5;

endpackage

// ----- rtl/core/efic_check.sv -----
// per-word frame state, checks and running error counters
// depends on efic_pkg and event_frame_integrity_checker_assert.svh
`include "event_frame_integrity_checker_assert.svh"

module efic_check #(
  parameter int BLOCKS_PER_FRAME = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  efic_pkg::efic_in_t  item,
  input  efic_pkg::efic_cfg_t cfg,
  output logic               res_valid,
  output efic_pkg::efic_out_t res
);
  import efic_pkg::*;

  localparam logic [9:0] LAST_BLK = 10'(BLOCKS_PER_FRAME - 1);

  logic [6:0]  pos_r, pos_nxt;
  logic [9:0]  blk_r, blk_nxt;
  logic [9:0]  last_blk_r, last_blk_nxt;
  logic [1:0]  ctl_cnt_r, ctl_cnt_nxt;
  logic [9:0]  dcnt_r, dcnt_nxt;
  logic [31:0] prev_r, prev_nxt;
  efic_flags_t flags_r, flags_nxt;
  logic [31:0] err_frames_r, err_frames_nxt;
  logic [31:0] dig_frames_r, dig_frames_nxt;
  logic [31:0] glob_frames_r, glob_frames_nxt;
  logic [31:0] ctl_frames_r, ctl_frames_nxt;

  always_comb begin
    logic [6:0]  pos_inc;
    logic [6:0]  blk_len;
    logic [10:0] dcnt_inc;
    logic [1:0]  ctl_inc;
    logic        clear;
    logic [2:0]  status;
    logic [10:0] seen;
    efic_flags_t flags_v;

    pos_nxt         = pos_r;
    blk_nxt         = blk_r;
    last_blk_nxt    = last_blk_r;
    ctl_cnt_nxt     = ctl_cnt_r;
    dcnt_nxt        = dcnt_r;
    prev_nxt        = prev_r;
    err_frames_nxt  = err_frames_r;
    dig_frames_nxt  = dig_frames_r;
    glob_frames_nxt = glob_frames_r;
    ctl_frames_nxt  = ctl_frames_r;
    flags_v         = flags_r;
    clear           = 1'b0;
    status          = ST_OK;
    seen            = {1'b0, dcnt_r};
    pos_inc         = pos_r + 7'd1;
    blk_len         = {1'b0, cfg.samples_per_block} + 7'd3;
    dcnt_inc        = {1'b0, dcnt_r} + 11'd1;
    ctl_inc         = (ctl_cnt_r == 2'd3) ? 2'd3 : ctl_cnt_r + 2'd1;

    if (item_valid) begin
      if (!item.is_control) begin
        if (pos_inc >= blk_len) begin
          pos_nxt = 7'd0;
          blk_nxt = blk_r + 10'd1;
        end else begin
          pos_nxt = pos_inc;
        end
        if (dcnt_inc > {1'b0, cfg.max_data_words}) begin
          clear  = 1'b1;
          status = ST_OVERFLOW;
          seen   = dcnt_inc;
        end else begin
          dcnt_nxt = dcnt_inc[9:0];
          prev_nxt = item.link_word;
          if (last_blk_r == LAST_BLK && pos_r == 7'd0) begin
            if (item.link_word != cfg.digitizer_crc_word) flags_v.dig = 1'b1;
          end else if (last_blk_r == LAST_BLK && pos_r == 7'd1) begin
            if (item.link_word[15:0] != item.link_word[31:16]) flags_v.final_crc = 1'b1;
          end else if (pos_r == 7'd0) begin
            // block header
          end else if (pos_r > {1'b0, cfg.samples_per_block} + 7'd1) begin
            // block trailer
          end else begin
            last_blk_nxt = blk_r;
          end
        end
      end else begin
        ctl_cnt_nxt = ctl_inc;
        if (ctl_inc == 2'd1 && item.link_word != cfg.open_word) flags_v.ctrl = 1'b1;
        if (ctl_inc == 2'd2 && item.link_word != cfg.close_word) begin
          flags_v.ctrl = 1'b1;
          clear        = 1'b1;
          status       = ST_BAD_STOP;
        end else if (item.link_word == cfg.close_word) begin
          clear = 1'b1;
          if (prev_r[15:0] != prev_r[31:16]) flags_v.glob = 1'b1;
          if (flags_v.dig || flags_v.glob || flags_v.ctrl) begin
            err_frames_nxt = err_frames_r + 32'd1;
          end
          if (flags_v.dig) begin
            dig_frames_nxt = dig_frames_r + 32'd1;
            status         = ST_DIG_CRC;
          end else if (flags_v.glob) begin
            glob_frames_nxt = glob_frames_r + 32'd1;
            status          = ST_GLOBAL_CRC;
          end else if (flags_v.ctrl) begin
            ctl_frames_nxt = ctl_frames_r + 32'd1;
            status         = ST_OPEN_WORD;
          end
        end
      end
    end

    res_valid              = clear;
    res.frame_status       = status;
    res.dig_crc_bad        = flags_v.dig;
    res.global_crc_bad     = flags_v.glob;
    res.control_bad        = flags_v.ctrl;
    res.final_crc_mismatch = flags_v.final_crc;
    res.words_seen         = seen;
    res.error_frames       = err_frames_nxt;
    res.dig_crc_frames     = dig_frames_nxt;
    res.global_crc_frames  = glob_frames_nxt;
    res.control_frames     = ctl_frames_nxt;

    flags_nxt = flags_v;
    // frame end or abort restarts the frame
    if (clear) begin
      pos_nxt      = 7'd0;
      blk_nxt      = 10'd0;
      last_blk_nxt = 10'd0;
      ctl_cnt_nxt  = 2'd0;
      dcnt_nxt     = 10'd0;
      flags_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      blk_r         <= '0;
      last_blk_r    <= '0;
      ctl_cnt_r     <= '0;
      dcnt_r        <= '0;
      prev_r        <= '0;
      flags_r       <= '0;
      err_frames_r  <= '0;
      dig_frames_r  <= '0;
      glob_frames_r <= '0;
      ctl_frames_r  <= '0;
    end else begin
      pos_r         <= pos_nxt;
      blk_r         <= blk_nxt;
      last_blk_r    <= last_blk_nxt;
      ctl_cnt_r     <= ctl_cnt_nxt;
      dcnt_r        <= dcnt_nxt;
      prev_r        <= prev_nxt;
      flags_r       <= flags_nxt;
      err_frames_r  <= err_frames_nxt;
      dig_frames_r  <= dig_frames_nxt;
      glob_frames_r <= glob_frames_nxt;
      ctl_frames_r  <= ctl_frames_nxt;
    end
  end

  `EFIC_ASSERT_NEXT(a_clear_after_result, res_valid,
      dcnt_r == 10'd0 && ctl_cnt_r == 2'd0 && flags_r == '0 && pos_r == 7'd0)
  `EFIC_ASSERT_NOW(a_error_frame_bump,
      res_valid && (res.frame_status == ST_DIG_CRC || res.frame_status == ST_GLOBAL_CRC ||
      res.frame_status == ST_OPEN_WORD), res.error_frames == err_frames_r + 32'd1)
  `EFIC_ASSERT_NEXT(a_counters_hold, !res_valid,
      $stable(err_frames_r) && $stable(dig_frames_r) && $stable(glob_frames_r) &&
      $stable(ctl_frames_r))
  `EFIC_ASSERT_NOW(a_abort_no_count,
      res_valid && (res.frame_status == ST_BAD_STOP || res.frame_status == ST_OVERFLOW),
      res.error_frames == err_frames_r && res.control_frames == ctl_frames_r)

endmodule

// ----- rtl/core/event_frame_integrity_checker.sv -----
// a word waits in the input register, is checked as it leaves it, and its result is registered onto out_data
// throughput: one link word per cycle; a result held by out_stall stalls the input
// once the input register is full; all checks sit in a single pass
// a word that ends or aborts a frame yields one result, other words none
// reset (rst_n low, synchronous) clears frame state, counters and config to defaults
// depends on efic_pkg and efic_check
module event_frame_integrity_checker #(
  parameter int BLOCKS_PER_FRAME = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  efic_pkg::efic_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output efic_pkg::efic_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import efic_pkg::*;

  efic_cfg_t cfg_r;
  logic      s1_valid_r;
  efic_in_t  s1_item_r;
  logic      out_valid_r;
  efic_out_t out_r;
  logic      s1_adv;
  logic      in_accept;
  logic      res_valid;
  efic_out_t res;

  assign cfg_ready = 1'b1;

  // the input register moves on whenever the result slot is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_block  <= RST_SAMPLES_PER_BLOCK;
      cfg_r.open_word          <= RST_OPEN_WORD;
      cfg_r.close_word         <= RST_CLOSE_WORD;
      cfg_r.digitizer_crc_word <= RST_DIG_CRC_WORD;
      cfg_r.max_data_words     <= RST_MAX_DATA_WORDS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLES_PER_BLOCK: cfg_r.samples_per_block  <= cfg_data[5:0];
        REG_OPEN_WORD:         cfg_r.open_word          <= cfg_data;
        REG_CLOSE_WORD:        cfg_r.close_word         <= cfg_data;
        REG_DIG_CRC_WORD:      cfg_r.digitizer_crc_word <= cfg_data;
        REG_MAX_DATA_WORDS:    cfg_r.max_data_words     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
  end

  efic_check #(
    .BLOCKS_PER_FRAME(BLOCKS_PER_FRAME)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(s1_adv),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
